[rtl/iptl_pkg.sv]
// Shared types and constants for the IPv4 prefix trie with longest-prefix match.
// No dependencies; iptl_walk, iptl_out_buf and the top level use it by scoped names.
package iptl_pkg;

  localparam int unsigned NODE_COUNT_DEF = 4096;
  localparam int unsigned ADDR_W         = 32;
  localparam int unsigned LEN_W          = 6;
  localparam logic [LEN_W-1:0] MAX_LEN   = 6'd32;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_DEL    = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_BAD    = 2'd3
  } op_e;

  typedef struct packed {
    logic             error;
    logic             hit;
    logic [LEN_W-1:0] match_len;
  } result_t;

endpackage

[rtl/iptl_ram.sv]
// Generic single-port synchronous RAM, one read or write per cycle, registered read.
// No dependencies.
module iptl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/iptl_walk.sv]
// Trie walker: sequencer that reads, modifies and writes the node memory level by level.
// Depends on iptl_pkg and iptl_ram.
module iptl_walk #(
  parameter int unsigned NODE_COUNT = iptl_pkg::NODE_COUNT_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       op_i,
  input  logic [iptl_pkg::ADDR_W-1:0]      address_i,
  input  logic [iptl_pkg::LEN_W-1:0]       prefix_len_i,
  output logic                             res_valid_o,
  input  logic                             res_free_i,
  output iptl_pkg::result_t                res_o
);

  localparam int unsigned AW = $clog2(NODE_COUNT);
  localparam int unsigned CW = $clog2(NODE_COUNT + 1);
  localparam int unsigned LW = iptl_pkg::LEN_W;
  localparam int unsigned EW = 2 * AW + 1 + LW;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_WALK,
    S_ALLOC,
    S_DONE
  } state_e;

  state_e                          state_q, state_d;
  iptl_pkg::op_e                   op_q, op_d;
  logic [iptl_pkg::ADDR_W-1:0]     addr_q, addr_d;
  logic [LW-1:0]                   len_q, len_d;
  logic [LW-1:0]                   depth_q, depth_d;
  logic [AW-1:0]                   node_q, node_d;
  logic [AW-1:0]                   new_q, new_d;
  logic                            fresh_q, fresh_d;
  logic [CW-1:0]                   used_q, used_d;
  logic                            found_q, found_d;
  logic [LW-1:0]                   best_q, best_d;
  iptl_pkg::result_t               res_q, res_d;

  logic                            mem_we;
  logic [AW-1:0]                   mem_addr;
  logic [EW-1:0]                   mem_wdata;
  logic [EW-1:0]                   mem_rdata;

  logic [EW-1:0]                   ent;
  logic [AW-1:0]                   e_left, e_right, child;
  logic                            e_mark;
  logic [LW-1:0]                   e_len;
  logic                            lk_found;
  logic [LW-1:0]                   lk_best;

  iptl_ram #(
    .WIDTH (EW),
    .DEPTH (NODE_COUNT)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // A freshly allocated node is known to be empty, so skip its read.
  assign ent      = fresh_q ? '0 : mem_rdata;
  assign e_left   = ent[EW-1 -: AW];
  assign e_right  = ent[EW-1-AW -: AW];
  assign e_mark   = ent[LW];
  assign e_len    = ent[LW-1:0];
  assign child    = addr_q[iptl_pkg::ADDR_W-1] ? e_right : e_left;
  assign lk_found = found_q | e_mark;
  assign lk_best  = e_mark ? e_len : best_q;

  assign in_stall_o  = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    addr_d    = addr_q;
    len_d     = len_q;
    depth_d   = depth_q;
    node_d    = node_q;
    new_d     = new_q;
    fresh_d   = fresh_q;
    used_d    = used_q;
    found_d   = found_q;
    best_d    = best_q;
    res_d     = res_q;
    mem_we    = 1'b0;
    mem_addr  = node_q;
    mem_wdata = '0;

    unique case (state_q)
      S_INIT: begin
        // clear the root entry once after reset
        mem_we   = 1'b1;
        mem_addr = '0;
        state_d  = S_IDLE;
      end

      S_IDLE: begin
        mem_addr = '0;
        if (in_valid_i) begin
          op_d    = iptl_pkg::op_e'(op_i);
          addr_d  = address_i;
          len_d   = prefix_len_i;
          depth_d = '0;
          node_d  = '0;
          fresh_d = 1'b0;
          found_d = 1'b0;
          best_d  = '0;
          if (iptl_pkg::op_e'(op_i) == iptl_pkg::OP_BAD ||
              (iptl_pkg::op_e'(op_i) != iptl_pkg::OP_LOOKUP &&
               prefix_len_i > iptl_pkg::MAX_LEN)) begin
            res_d   = '{error: 1'b1, hit: 1'b0, match_len: '0};
            state_d = S_DONE;
          end else begin
            state_d = S_WALK;
          end
        end
      end

      S_WALK: begin
        unique case (op_q)
          iptl_pkg::OP_LOOKUP: begin
            found_d = lk_found;
            best_d  = lk_best;
            if (depth_q == iptl_pkg::MAX_LEN || child == '0) begin
              res_d   = '{error: 1'b0, hit: lk_found,
                          match_len: lk_found ? lk_best : '0};
              state_d = S_DONE;
            end else begin
              node_d   = child;
              mem_addr = child;
              depth_d  = depth_q + LW'(1);
              addr_d   = addr_q << 1;
              fresh_d  = 1'b0;
            end
          end

          iptl_pkg::OP_ADD: begin
            if (depth_q == len_q) begin
              mem_we    = 1'b1;
              mem_wdata = {e_left, e_right, 1'b1, len_q};
              res_d     = '{error: 1'b0, hit: 1'b0, match_len: '0};
              state_d   = S_DONE;
            end else if (child != '0) begin
              node_d   = child;
              mem_addr = child;
              depth_d  = depth_q + LW'(1);
              addr_d   = addr_q << 1;
              fresh_d  = 1'b0;
            end else if (used_q >= CW'(NODE_COUNT)) begin
              res_d   = '{error: 1'b1, hit: 1'b0, match_len: '0};
              state_d = S_DONE;
            end else begin
              // link the new node into the parent, clear it next cycle
              mem_we    = 1'b1;
              mem_wdata = addr_q[iptl_pkg::ADDR_W-1] ?
                          {e_left, used_q[AW-1:0], e_mark, e_len} :
                          {used_q[AW-1:0], e_right, e_mark, e_len};
              new_d     = used_q[AW-1:0];
              used_d    = used_q + CW'(1);
              state_d   = S_ALLOC;
            end
          end

          iptl_pkg::OP_DEL: begin
            if (depth_q == len_q) begin
              if (e_mark && e_len == len_q) begin
                mem_we    = 1'b1;
                mem_wdata = {e_left, e_right, 1'b0, LW'(0)};
                res_d     = '{error: 1'b0, hit: 1'b0, match_len: '0};
              end else begin
                res_d     = '{error: 1'b1, hit: 1'b0, match_len: '0};
              end
              state_d = S_DONE;
            end else if (child == '0) begin
              res_d   = '{error: 1'b1, hit: 1'b0, match_len: '0};
              state_d = S_DONE;
            end else begin
              node_d   = child;
              mem_addr = child;
              depth_d  = depth_q + LW'(1);
              addr_d   = addr_q << 1;
              fresh_d  = 1'b0;
            end
          end

          default: begin
            res_d   = '{error: 1'b1, hit: 1'b0, match_len: '0};
            state_d = S_DONE;
          end
        endcase
      end

      S_ALLOC: begin
        mem_we    = 1'b1;
        mem_addr  = new_q;
        mem_wdata = '0;
        node_d    = new_q;
        fresh_d   = 1'b1;
        depth_d   = depth_q + LW'(1);
        addr_d    = addr_q << 1;
        state_d   = S_WALK;
      end

      S_DONE: begin
        if (res_free_i) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      op_q    <= iptl_pkg::OP_ADD;
      addr_q  <= '0;
      len_q   <= '0;
      depth_q <= '0;
      node_q  <= '0;
      new_q   <= '0;
      fresh_q <= 1'b0;
      used_q  <= CW'(1);
      found_q <= 1'b0;
      best_q  <= '0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      addr_q  <= addr_d;
      len_q   <= len_d;
      depth_q <= depth_d;
      node_q  <= node_d;
      new_q   <= new_d;
      fresh_q <= fresh_d;
      used_q  <= used_d;
      found_q <= found_d;
      best_q  <= best_d;
      res_q   <= res_d;
    end
  end

endmodule

[rtl/iptl_out_buf.sv]
// Output register for results; it frees the walker by taking its result when empty or not stalled.
// Depends on iptl_pkg.
module iptl_out_buf (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       res_valid_i,
  output logic                       res_free_o,
  input  iptl_pkg::result_t          res_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       error_o,
  output logic                       hit_o,
  output logic [iptl_pkg::LEN_W-1:0] match_len_o
);

  logic              valid_q, valid_d;
  iptl_pkg::result_t res_q, res_d;

  assign res_free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    res_d   = res_q;
    if (res_free_o) begin
      valid_d = res_valid_i;
      if (res_valid_i) begin
        res_d = res_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      res_q   <= '0;
    end else begin
      valid_q <= valid_d;
      res_q   <= res_d;
    end
  end

  assign out_valid_o = valid_q;
  assign error_o     = res_q.error;
  assign hit_o       = res_q.hit;
  assign match_len_o = res_q.match_len;

endmodule

[rtl/ipv4_prefix_trie_lpm.sv]
// Top level of the IPv4 binary trie with longest-prefix match.
// Depends on iptl_pkg, iptl_walk (with iptl_ram) and iptl_out_buf.
//
//   channel  handshake               payload
//   in       in_valid_i / in_stall_o op_i, address_i, prefix_len_i
//   out      out_valid_o/ out_stall_i error_o, hit_o, match_len_o
//
// One request at a time. A request is accepted in the idle state, then reads one trie
// level of the node memory per walk step (plus an allocation step where add allocates
// a node), then hands its result to the output register from the done state. A bad op,
// or a length above 32 on add or delete, goes from accept straight to the done state.
// After reset, the init state clears the root entry before the first request is taken.
// A stalled result waits in the output register; the walker holds its own result
// only while that register is occupied and stalled.
module ipv4_prefix_trie_lpm #(
  parameter int unsigned NODE_COUNT = iptl_pkg::NODE_COUNT_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       op_i,
  input  logic [iptl_pkg::ADDR_W-1:0]      address_i,
  input  logic [iptl_pkg::LEN_W-1:0]       prefix_len_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             error_o,
  output logic                             hit_o,
  output logic [iptl_pkg::LEN_W-1:0]       match_len_o
);

  logic              res_valid;
  logic              res_free;
  iptl_pkg::result_t res;

  // walk the trie, read-modify-write of the node memory
  iptl_walk #(
    .NODE_COUNT (NODE_COUNT)
  ) u_walk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .address_i    (address_i),
    .prefix_len_i (prefix_len_i),
    .res_valid_o  (res_valid),
    .res_free_i   (res_free),
    .res_o        (res)
  );

  // hold the finished result until the consumer takes it
  iptl_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_free_o  (res_free),
    .res_i       (res),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .error_o     (error_o),
    .hit_o       (hit_o),
    .match_len_o (match_len_o)
  );

endmodule
